[design/csb_pkg.sv]
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types, constants and helpers for the clipped sprite blitter: frame
// store geometry, command codes, register indexes and the pixel layout.
// ----------------------------------------------------------------------------
package csb_pkg;

  // frame store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = $clog2(DEPTH);

  // sprite limits
  localparam int SPRITE_MAX = 256;
  localparam int TEX_W      = $clog2(SPRITE_MAX);

  // field widths
  localparam int CMD_W     = 3;
  localparam int COORD_W   = 13;
  localparam int DIM_W     = 9;
  localparam int CHAN_W    = 8;
  localparam int TOP_W     = COORD_W + 1;
  localparam int POS_W     = COORD_W + 2;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 4 * CHAN_W;

  // fourth byte written by a clear with a non-gray colour (opaque) and by a set pixel (clear)
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 3'd0,
    CMD_SET   = 3'd1,
    CMD_BEGIN = 3'd2,
    CMD_TEXEL = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 1'b1;

  // stored pixel, fourth byte on top
  typedef struct packed {
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } pixel_t;

  // blend request: destination pixel and source texel (alpha in src.a)
  typedef struct packed {
    pixel_t dst;
    pixel_t src;
  } blend_req_t;

  // effective screen dimension: zero acts as one, clamp to the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int mx);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > mx) begin
      res = DIM_W'(mx);
    end
    return res;
  endfunction

endpackage

[design/clipped_alpha_sprite_blitter_top.sv]
// ----------------------------------------------------------------------------
// clipped_alpha_sprite_blitter_top
// Frame buffer blitter: clear, set pixel, begin sprite, blended sprite texel
// and read pixel over a synchronous frame store, one command at a time.
// ----------------------------------------------------------------------------
// Flow: a read pixel result is registered through S_ADDR, S_READ and S_RESULT
//   when on screen, through S_ADDR and S_RESULT when off screen.
// Occupancy: set pixel, begin sprite, skipped texels and unused codes pass S_ADDR
//   only, a drawn texel S_ADDR, S_READ and S_BLEND; a clear sweeps width*height
//   pixels in S_CLEAR; a read also waits while out_stall holds.
// Reset: control, sprite state and screen size (256 x 256); frame store kept.
module clipped_alpha_sprite_blitter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [csb_pkg::CMD_W-1:0]     in_command,
  input  logic [csb_pkg::COORD_W-1:0]   in_x_pos,
  input  logic [csb_pkg::COORD_W-1:0]   in_y_pos,
  input  logic [csb_pkg::DIM_W-1:0]     in_size_w,
  input  logic [csb_pkg::DIM_W-1:0]     in_size_h,
  input  logic [csb_pkg::CHAN_W-1:0]    in_red,
  input  logic [csb_pkg::CHAN_W-1:0]    in_green,
  input  logic [csb_pkg::CHAN_W-1:0]    in_blue,
  input  logic [csb_pkg::CHAN_W-1:0]    in_alpha,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [csb_pkg::CHAN_W-1:0]    out_red,
  output logic [csb_pkg::CHAN_W-1:0]    out_green,
  output logic [csb_pkg::CHAN_W-1:0]    out_blue,
  output logic [csb_pkg::CHAN_W-1:0]    out_alpha,
  output logic                          out_on_screen,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csb_pkg::DIM_W-1:0]     cfg_data
);
  import csb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_BLEND,
    S_RESULT,
    S_CLEAR
  } state_t;

  state_t             state_r, state_nxt;

  // configuration
  logic [DIM_W-1:0]   scr_w_r, scr_w_nxt;
  logic [DIM_W-1:0]   scr_h_r, scr_h_nxt;
  logic [DIM_W-1:0]   eff_w, eff_h;

  // sprite state
  logic [COORD_W-1:0] spr_left_r, spr_left_nxt;
  logic [TOP_W-1:0]   spr_top_r, spr_top_nxt;
  logic [DIM_W-1:0]   spr_cols_r, spr_cols_nxt;
  logic [DIM_W-1:0]   spr_rows_r, spr_rows_nxt;
  logic [TEX_W-1:0]   tex_col_r, tex_col_nxt;
  logic [TEX_W-1:0]   tex_row_r, tex_row_nxt;
  logic               spr_active_r, spr_active_nxt;

  // latched command
  cmd_t               cmd_r, cmd_nxt;
  logic [POS_W-1:0]   pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]   pos_y_r, pos_y_nxt;
  pixel_t             src_r, src_nxt;
  logic               tex_go_r, tex_go_nxt;
  logic               rd_on_r, rd_on_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;

  // clear sweep
  logic [X_W-1:0]     clr_x_r, clr_x_nxt;
  logic [Y_W-1:0]     clr_y_r, clr_y_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  pixel_t             out_pix_r, out_pix_nxt;
  logic               out_on_r, out_on_nxt;

  // memory and blend
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_addr;
  pixel_t             ram_wdata;
  logic [PIX_W-1:0]   ram_rdata;
  blend_req_t         blend_req;
  pixel_t             blend_out;

  // helpers
  logic               in_accept;
  logic               pos_on;
  logic [ADDR_W-1:0]  pos_addr;
  logic [ADDR_W-1:0]  clr_addr;
  logic               clr_x_last, clr_y_last;
  pixel_t             clr_pix;
  logic [DIM_W-1:0]   size_w_sat, size_h_sat;
  logic [TEX_W:0]     col_inc, row_inc;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign eff_w = eff_dim(scr_w_r, MAX_WIDTH);
  assign eff_h = eff_dim(scr_h_r, MAX_HEIGHT);

  // clipping of the latched position
  assign pos_on = !pos_x_r[POS_W-1] && !pos_y_r[POS_W-1] &&
                  (pos_x_r[POS_W-2:0] < (POS_W-1)'(eff_w)) &&
                  (pos_y_r[POS_W-2:0] < (POS_W-1)'(eff_h));
  assign pos_addr = ADDR_W'(ADDR_W'(pos_y_r[Y_W-1:0]) * ADDR_W'(MAX_WIDTH)) +
                    ADDR_W'(pos_x_r[X_W-1:0]);

  // clear sweep address and colour
  assign clr_addr   = ADDR_W'(ADDR_W'(clr_y_r) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(clr_x_r);
  assign clr_x_last = (clr_x_r == X_W'(eff_w - 1'b1));
  assign clr_y_last = (clr_y_r == Y_W'(eff_h - 1'b1));
  always_comb begin
    clr_pix   = src_r;
    clr_pix.a = ALPHA_OPAQUE;
    if ((src_r.r == src_r.g) && (src_r.g == src_r.b)) begin
      clr_pix.a = src_r.r;
    end
  end

  // sprite size saturation and texel walk
  assign size_w_sat = (in_size_w > DIM_W'(SPRITE_MAX)) ? DIM_W'(SPRITE_MAX) : in_size_w;
  assign size_h_sat = (in_size_h > DIM_W'(SPRITE_MAX)) ? DIM_W'(SPRITE_MAX) : in_size_h;
  assign col_inc    = {1'b0, tex_col_r} + 1'b1;
  assign row_inc    = {1'b0, tex_row_r} + 1'b1;

  // blend operands: stored pixel and latched texel
  assign blend_req.dst = pixel_t'(ram_rdata);
  assign blend_req.src = src_r;

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    scr_w_nxt      = scr_w_r;
    scr_h_nxt      = scr_h_r;
    spr_left_nxt   = spr_left_r;
    spr_top_nxt    = spr_top_r;
    spr_cols_nxt   = spr_cols_r;
    spr_rows_nxt   = spr_rows_r;
    tex_col_nxt    = tex_col_r;
    tex_row_nxt    = tex_row_r;
    spr_active_nxt = spr_active_r;
    cmd_nxt        = cmd_r;
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    src_nxt        = src_r;
    tex_go_nxt     = tex_go_r;
    rd_on_nxt      = rd_on_r;
    addr_nxt       = addr_r;
    clr_x_nxt      = clr_x_r;
    clr_y_nxt      = clr_y_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_pix_nxt    = out_pix_r;
    out_on_nxt     = out_on_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_addr       = pos_addr;
    ram_wdata      = src_r;

    // configuration writes
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_W: scr_w_nxt = cfg_data;
        REG_SCREEN_H: scr_h_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      // take a command, update sprite state right away
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt    = cmd_t'(in_command);
          src_nxt    = '{a: in_alpha, r: in_red, g: in_green, b: in_blue};
          pos_x_nxt  = {{2{in_x_pos[COORD_W-1]}}, in_x_pos};
          pos_y_nxt  = {{2{in_y_pos[COORD_W-1]}}, in_y_pos};
          tex_go_nxt = 1'b0;
          state_nxt  = S_ADDR;
          case (cmd_t'(in_command))
            CMD_BEGIN: begin
              spr_left_nxt   = in_x_pos;
              spr_top_nxt    = {in_y_pos[COORD_W-1], in_y_pos} - TOP_W'(size_h_sat);
              spr_cols_nxt   = size_w_sat;
              spr_rows_nxt   = size_h_sat;
              tex_col_nxt    = '0;
              tex_row_nxt    = '0;
              spr_active_nxt = (size_w_sat != '0) && (size_h_sat != '0);
            end
            CMD_TEXEL: begin
              pos_x_nxt  = {{2{spr_left_r[COORD_W-1]}}, spr_left_r} + POS_W'(tex_col_r);
              pos_y_nxt  = {spr_top_r[TOP_W-1], spr_top_r} + POS_W'(tex_row_r);
              tex_go_nxt = spr_active_r && (in_alpha != '0);
              if (spr_active_r) begin
                tex_col_nxt = col_inc[TEX_W-1:0];
                if (DIM_W'(col_inc) >= spr_cols_r) begin
                  tex_col_nxt = '0;
                  tex_row_nxt = row_inc[TEX_W-1:0];
                  if (DIM_W'(row_inc) >= spr_rows_r) begin
                    tex_row_nxt    = '0;
                    spr_active_nxt = 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      // clip and dispatch to the frame store
      S_ADDR: begin
        addr_nxt  = pos_addr;
        rd_on_nxt = pos_on;
        state_nxt = S_IDLE;
        case (cmd_r)
          CMD_CLEAR: begin
            clr_x_nxt = '0;
            clr_y_nxt = '0;
            state_nxt = S_CLEAR;
          end
          CMD_SET: begin
            ram_we      = pos_on;
            ram_wdata.a = ALPHA_CLEAR;
          end
          CMD_TEXEL: begin
            if (pos_on && tex_go_r) begin
              ram_re    = 1'b1;
              state_nxt = S_READ;
            end
          end
          CMD_READ: begin
            ram_re    = pos_on;
            state_nxt = pos_on ? S_READ : S_RESULT;
          end
          default: ;
        endcase
      end

      // stored pixel is at the read port now
      S_READ: begin
        state_nxt = (cmd_r == CMD_TEXEL) ? S_BLEND : S_RESULT;
      end

      // write back the blended pixel
      S_BLEND: begin
        ram_we    = 1'b1;
        ram_addr  = addr_r;
        ram_wdata = blend_out;
        state_nxt = S_IDLE;
      end

      // load the result register once it is free
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_on_nxt    = rd_on_r;
          out_pix_nxt   = rd_on_r ? pixel_t'(ram_rdata) : '0;
          state_nxt     = S_IDLE;
        end
      end

      // one pixel per cycle over the visible screen
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = clr_pix;
        clr_x_nxt = clr_x_r + 1'b1;
        if (clr_x_last) begin
          clr_x_nxt = '0;
          clr_y_nxt = clr_y_r + 1'b1;
          if (clr_y_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scr_w_r      <= DIM_W'(MAX_WIDTH);
      scr_h_r      <= DIM_W'(MAX_HEIGHT);
      spr_left_r   <= '0;
      spr_top_r    <= '0;
      spr_cols_r   <= '0;
      spr_rows_r   <= '0;
      tex_col_r    <= '0;
      tex_row_r    <= '0;
      spr_active_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scr_w_r      <= scr_w_nxt;
      scr_h_r      <= scr_h_nxt;
      spr_left_r   <= spr_left_nxt;
      spr_top_r    <= spr_top_nxt;
      spr_cols_r   <= spr_cols_nxt;
      spr_rows_r   <= spr_rows_nxt;
      tex_col_r    <= tex_col_nxt;
      tex_row_r    <= tex_row_nxt;
      spr_active_r <= spr_active_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    pos_x_r   <= pos_x_nxt;
    pos_y_r   <= pos_y_nxt;
    src_r     <= src_nxt;
    tex_go_r  <= tex_go_nxt;
    rd_on_r   <= rd_on_nxt;
    addr_r    <= addr_nxt;
    clr_x_r   <= clr_x_nxt;
    clr_y_r   <= clr_y_nxt;
    out_pix_r <= out_pix_nxt;
    out_on_r  <= out_on_nxt;
  end

  // frame store
  csb_frame_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // texel blend unit
  csb_blend u_blend (
    .clk    (clk),
    .req    (blend_req),
    .result (blend_out)
  );

  // result ports
  assign out_valid     = out_valid_r;
  assign out_red       = out_pix_r.r;
  assign out_green     = out_pix_r.g;
  assign out_blue      = out_pix_r.b;
  assign out_alpha     = out_pix_r.a;
  assign out_on_screen = out_on_r;

`ifndef SYNTH
  // read and write never share a cycle on the frame store
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("frame store read and write in the same cycle");

  // a new result only comes from the result state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("result appeared outside the result state");

  // closed sprite leaves the texel walk at the origin
  a_idle_sprite_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !spr_active_r |-> (tex_col_r == '0) && (tex_row_r == '0))
    else $error("texel counters moved without an open sprite");

  // open sprite walk stays inside its frame
  a_sprite_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    spr_active_r |-> (DIM_W'(tex_col_r) < spr_cols_r) && (DIM_W'(tex_row_r) < spr_rows_r))
    else $error("texel counters beyond the sprite frame");

  // clear sweep stays on the visible screen
  a_clear_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (DIM_W'(clr_x_r) < eff_w) && (DIM_W'(clr_y_r) < eff_h))
    else $error("clear sweep left the visible screen");
`endif

endmodule

[design/csb_frame_ram.sv]
// ----------------------------------------------------------------------------
// csb_frame_ram
// Generic single-port-write, single-port-read synchronous memory with a
// registered read.
// ----------------------------------------------------------------------------
module csb_frame_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/csb_blend.sv]
// ----------------------------------------------------------------------------
// csb_blend
// Alpha blend of one texel onto one stored pixel. Products are registered;
// the result is dst + floor(alpha*(src-dst)/256) per colour byte, or the
// source colour when alpha is opaque. The fourth byte is kept.
// ----------------------------------------------------------------------------
module csb_blend (
  input  logic               clk,
  input  csb_pkg::blend_req_t req,
  output csb_pkg::pixel_t     result
);
  import csb_pkg::*;

  logic [CHAN_W-1:0]     dst_c [3];
  logic [CHAN_W-1:0]     src_c [3];
  logic signed [CHAN_W:0]     diff   [3];
  logic signed [2*CHAN_W+1:0] prod   [3];
  logic [CHAN_W-1:0]     step_r [3];
  pixel_t                dst_r;
  pixel_t                src_r;
  logic                  opaque_r;
  logic [CHAN_W-1:0]     mix_c  [3];

  // split into colour lanes
  assign dst_c[0] = req.dst.r;
  assign dst_c[1] = req.dst.g;
  assign dst_c[2] = req.dst.b;
  assign src_c[0] = req.src.r;
  assign src_c[1] = req.src.g;
  assign src_c[2] = req.src.b;

  // signed difference times alpha, one multiplier per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({1'b0, src_c[i]}) - $signed({1'b0, dst_c[i]});
      prod[i] = $signed({1'b0, req.src.a}) * diff[i];
    end
  end

  // product register; floor of prod/256 modulo 256 is bits 15:8
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      step_r[i] <= prod[i][2*CHAN_W-1:CHAN_W];
    end
    dst_r    <= req.dst;
    src_r    <= req.src;
    opaque_r <= (req.src.a == ALPHA_OPAQUE);
  end

  assign mix_c[0] = dst_r.r + step_r[0];
  assign mix_c[1] = dst_r.g + step_r[1];
  assign mix_c[2] = dst_r.b + step_r[2];

  // final select
  always_comb begin
    result.a = dst_r.a;
    if (opaque_r) begin
      result.r = src_r.r;
      result.g = src_r.g;
      result.b = src_r.b;
    end else begin
      result.r = mix_c[0];
      result.g = mix_c[1];
      result.b = mix_c[2];
    end
  end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clipped sprite blitter. A mirror of the frame
// store follows every accepted command transaction and queues the pixel that
// each read must return. Commands go out in random bursts, the result side
// stalls on a shifting pattern, and the screen size is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import csb_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 280000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASE_ITEMS    = 22;
  localparam int PHASE_COUNT    = 8;
  localparam int CLEAR_AREA_MAX = 4096;

  // command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_RING, STALL_HEAVY} stall_mode_t;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic [DIM_W-1:0]          size_w;
    logic [DIM_W-1:0]          size_h;
    logic [CHAN_W-1:0]         red;
    logic [CHAN_W-1:0]         green;
    logic [CHAN_W-1:0]         blue;
    logic [CHAN_W-1:0]         alpha;
  } blit_cmd_t;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              on_screen;
  } readback_t;

  // mirror of the frame store, sprite walker and screen size
  class frame_mirror;
    pixel_t            frame [DEPTH];
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    int                spr_left;
    int                spr_top;
    int                spr_cols;
    int                spr_rows;
    int                tex_col;
    int                tex_row;
    bit                spr_open;
    readback_t         pending_reads [$];
    int                errors;

    function new();
      width_reg  = DIM_W'(MAX_WIDTH);
      height_reg = DIM_W'(MAX_HEIGHT);
      spr_left   = 0;
      spr_top    = 0;
      spr_cols   = 0;
      spr_rows   = 0;
      tex_col    = 0;
      tex_row    = 0;
      spr_open   = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      if (idx == REG_SCREEN_W) begin
        width_reg = val;
      end else begin
        height_reg = val;
      end
    endfunction

    // zero acts as one, oversize acts as the store size
    function int clamp_dim(logic [DIM_W-1:0] v, int mx);
      if (v == '0) return 1;
      return (int'(v) > mx) ? mx : int'(v);
    endfunction

    function int eff_w();
      return clamp_dim(width_reg, MAX_WIDTH);
    endfunction

    function int eff_h();
      return clamp_dim(height_reg, MAX_HEIGHT);
    endfunction

    function bit visible(int x, int y);
      return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
    endfunction

    // dst + floor(alpha * (src - dst) / 256), kept to one byte
    function logic [CHAN_W-1:0] blend_chan(int dst, int src, int a);
      int prod;
      prod = a * (src - dst);
      return CHAN_W'(dst + (prod >>> 8));
    endfunction

    function void apply_command(blit_cmd_t c);
      int        x;
      int        y;
      int        sw;
      int        sh;
      int        px;
      int        py;
      int        i;
      int        j;
      pixel_t    fill;
      pixel_t    d;
      readback_t rb;
      x  = c.x_pos;
      y  = c.y_pos;
      sw = c.size_w;
      sh = c.size_h;
      case (c.cmd)
        CMD_CLEAR: begin
          // gray fills all four bytes, any other colour is opaque
          if (c.red == c.green && c.green == c.blue) begin
            fill = {c.red, c.red, c.red, c.red};
          end else begin
            fill = {ALPHA_OPAQUE, c.red, c.green, c.blue};
          end
          for (j = 0; j < eff_h(); j++) begin
            for (i = 0; i < eff_w(); i++) begin
              frame[j * MAX_WIDTH + i] = fill;
            end
          end
        end
        CMD_SET: begin
          if (visible(x, y)) begin
            frame[y * MAX_WIDTH + x] = {ALPHA_CLEAR, c.red, c.green, c.blue};
          end
        end
        CMD_BEGIN: begin
          if (sw > SPRITE_MAX) sw = SPRITE_MAX;
          if (sh > SPRITE_MAX) sh = SPRITE_MAX;
          spr_left = x;
          spr_top  = y - sh;
          spr_cols = sw;
          spr_rows = sh;
          tex_col  = 0;
          tex_row  = 0;
          spr_open = (sw != 0 && sh != 0);
        end
        CMD_TEXEL: begin
          if (spr_open) begin
            px = spr_left + tex_col;
            py = spr_top + tex_row;
            if (visible(px, py) && c.alpha != ALPHA_CLEAR) begin
              d = frame[py * MAX_WIDTH + px];
              if (c.alpha == ALPHA_OPAQUE) begin
                d.r = c.red;
                d.g = c.green;
                d.b = c.blue;
              end else begin
                d.r = blend_chan(d.r, c.red, c.alpha);
                d.g = blend_chan(d.g, c.green, c.alpha);
                d.b = blend_chan(d.b, c.blue, c.alpha);
              end
              frame[py * MAX_WIDTH + px] = d;
            end
            // raster walk, close after the last texel
            tex_col++;
            if (tex_col >= spr_cols) begin
              tex_col = 0;
              tex_row++;
              if (tex_row >= spr_rows) begin
                tex_row  = 0;
                spr_open = 1'b0;
              end
            end
          end
        end
        CMD_READ: begin
          if (visible(x, y)) begin
            d            = frame[y * MAX_WIDTH + x];
            rb.red       = d.r;
            rb.green     = d.g;
            rb.blue      = d.b;
            rb.alpha     = d.a;
            rb.on_screen = 1'b1;
          end else begin
            rb.red       = '0;
            rb.green     = '0;
            rb.blue      = '0;
            rb.alpha     = '0;
            rb.on_screen = 1'b0;
          end
          pending_reads = {pending_reads, rb};
        end
        default: begin
        end
      endcase
    endfunction

    function void check_field(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_readback(readback_t got);
      readback_t want;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected read result, expected none, actual %0d %0d %0d %0d %0d",
                 $time, got.red, got.green, got.blue, got.alpha, got.on_screen);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      check_field("out_red", want.red, got.red);
      check_field("out_green", want.green, got.green);
      check_field("out_blue", want.blue, got.blue);
      check_field("out_alpha", want.alpha, got.alpha);
      check_field("out_on_screen", CHAN_W'(want.on_screen), CHAN_W'(got.on_screen));
    endfunction
  endclass

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command    = '0;
  logic [COORD_W-1:0]  in_x_pos      = '0;
  logic [COORD_W-1:0]  in_y_pos      = '0;
  logic [DIM_W-1:0]    in_size_w     = '0;
  logic [DIM_W-1:0]    in_size_h     = '0;
  logic [CHAN_W-1:0]   in_red        = '0;
  logic [CHAN_W-1:0]   in_green      = '0;
  logic [CHAN_W-1:0]   in_blue       = '0;
  logic [CHAN_W-1:0]   in_alpha      = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [CHAN_W-1:0]   out_red;
  logic [CHAN_W-1:0]   out_green;
  logic [CHAN_W-1:0]   out_blue;
  logic [CHAN_W-1:0]   out_alpha;
  logic                out_on_screen;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [DIM_W-1:0]    cfg_data      = '0;

  frame_mirror mirror;
  blit_cmd_t   pending_cmds [$];
  int          phase_count  = 0;
  int          burst_left   = 0;
  int          quiet_cycles = 0;
  stall_mode_t stall_mode   = STALL_NONE;
  int          stall_left   = 0;
  logic [7:0]  stall_ring   = '0;
  readback_t   seen;

  clipped_alpha_sprite_blitter_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_x_pos      (in_x_pos),
    .in_y_pos      (in_y_pos),
    .in_size_w     (in_size_w),
    .in_size_h     (in_size_h),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_alpha      (in_alpha),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_on_screen (out_on_screen),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // result side stall, mode redrawn at random after a stretch of random length
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 256);
      stall_ring <= 8'($urandom);
    end else begin
      stall_left <= stall_left - 1;
      stall_ring <= {stall_ring[0], stall_ring[7:1]};
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_RING:  out_stall <= stall_ring[0];
      default:     out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.red       = out_red;
      seen.green     = out_green;
      seen.blue      = out_blue;
      seen.alpha     = out_alpha;
      seen.on_screen = out_on_screen;
      mirror.check_readback(seen);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_item(blit_cmd_t c, bit counts);
    pending_cmds = {pending_cmds, c};
    if (counts) phase_count++;
  endfunction

  // command with every unused field random
  function automatic blit_cmd_t rand_item(logic [CMD_W-1:0] cmd, int x, int y);
    blit_cmd_t c;
    c.cmd    = cmd;
    c.x_pos  = COORD_W'(x);
    c.y_pos  = COORD_W'(y);
    c.size_w = DIM_W'($urandom);
    c.size_h = DIM_W'($urandom);
    c.red    = CHAN_W'($urandom);
    c.green  = CHAN_W'($urandom);
    c.blue   = CHAN_W'($urandom);
    c.alpha  = CHAN_W'($urandom);
    return c;
  endfunction

  // coordinate in [lo, hi], now and then anywhere in the field range
  function automatic int near_coord(int lo, int hi);
    if ($urandom_range(0, 11) == 0) return int'($urandom_range(0, 8191)) - 4096;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic void push_read(int x, int y);
    push_item(rand_item(CMD_READ, x, y), 1'b1);
  endfunction

  function automatic void push_set(int x, int y, logic [CHAN_W-1:0] r,
                                   logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
    blit_cmd_t c;
    c       = rand_item(CMD_SET, x, y);
    c.red   = r;
    c.green = g;
    c.blue  = b;
    push_item(c, 1'b1);
  endfunction

  function automatic void push_clear(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                     logic [CHAN_W-1:0] b);
    blit_cmd_t c;
    c       = rand_item(CMD_CLEAR, $urandom, $urandom);
    c.red   = r;
    c.green = g;
    c.blue  = b;
    push_item(c, 1'b1);
  endfunction

  function automatic void push_texel(logic [CHAN_W-1:0] a, bit counts);
    blit_cmd_t c;
    c       = rand_item(CMD_TEXEL, $urandom, $urandom);
    c.alpha = a;
    push_item(c, counts);
  endfunction

  // begin sprite then n texels, with a read slipped in now and then
  function automatic void push_sprite(int x, int y, int sw, int sh, int n);
    blit_cmd_t         c;
    int                live;
    int                pick;
    logic [CHAN_W-1:0] a;
    c        = rand_item(CMD_BEGIN, x, y);
    c.size_w = DIM_W'(sw);
    c.size_h = DIM_W'(sh);
    push_item(c, 1'b1);
    live = ((sw > SPRITE_MAX) ? SPRITE_MAX : sw) * ((sh > SPRITE_MAX) ? SPRITE_MAX : sh);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 12) == 0) begin
        push_read(near_coord(-1, mirror.eff_w()), near_coord(-1, mirror.eff_h()));
      end
      pick = $urandom_range(0, 19);
      if (pick < 3) a = ALPHA_CLEAR;
      else if (pick < 8) a = ALPHA_OPAQUE;
      else if (pick < 10) a = CHAN_W'(1);
      else if (pick < 12) a = CHAN_W'(254);
      else a = CHAN_W'($urandom);
      push_texel(a, k < live);
    end
  endfunction

  // send every queued command, bursts of random length with random gaps
  task automatic run_stim();
    blit_cmd_t c;
    int        gap;
    while (pending_cmds.size() > 0) begin
      c = pending_cmds.pop_front();
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      in_valid   <= 1'b1;
      in_command <= c.cmd;
      in_x_pos   <= c.x_pos;
      in_y_pos   <= c.y_pos;
      in_size_w  <= c.size_w;
      in_size_h  <= c.size_h;
      in_red     <= c.red;
      in_green   <= c.green;
      in_blue    <= c.blue;
      in_alpha   <= c.alpha;
      do @(posedge clk); while (in_stall);
      mirror.apply_command(c);
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // an off-screen read behind all queued work, then wait for every result
  task automatic drain();
    push_item(rand_item(CMD_READ, -1, -1), 1'b0);
    run_stim();
    while (mirror.pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                p;
    int                pick;
    int                sw;
    int                sh;
    int                sx;
    int                sy;
    int                x;
    int                y;
    logic [DIM_W-1:0]  scr_w;
    logic [DIM_W-1:0]  scr_h;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] probe_alphas [6];
    mirror = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full gray clear first so every pixel is defined
    push_clear(8'h80, 8'h80, 8'h80);
    push_read(0, 0);
    push_read(255, 255);
    push_read(256, 0);
    push_read(0, -1);
    push_read(-4096, 4095);
    push_read(4095, -4096);
    push_set(255, 255, 8'hff, 8'h00, 8'hff);
    push_read(255, 255);
    push_set(256, 7, 8'h00, 8'hff, 8'h00);
    push_set(-1, -1, 8'h12, 8'h34, 8'h56);
    // sprite over the right edge, every blend case
    probe_alphas = '{8'd255, 8'd0, 8'd128, 8'd1, 8'd254, 8'd255};
    push_sprite(254, 2, 3, 2, 0);
    foreach (probe_alphas[k]) push_texel(probe_alphas[k], 1'b1);
    push_texel(8'd255, 1'b0);
    push_read(254, 0);
    push_read(255, 0);
    push_read(254, 1);
    push_read(255, 1);
    // zero sized sprites open nothing
    push_sprite(10, 10, 0, 3, 1);
    push_sprite(10, 10, 3, 0, 1);
    push_read(10, 7);
    for (int k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++) begin
      push_item(rand_item(CMD_W'(k), $urandom, $urandom), 1'b0);
    end
    run_stim();

    // random phases, one screen size each
    for (p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin scr_w = '0; scr_h = 9'd511; end
        1: begin scr_w = 9'd511; scr_h = '0; end
        2: begin scr_w = 9'd1; scr_h = 9'd1; end
        3: begin
          scr_w = DIM_W'($urandom_range(2, 24));
          scr_h = DIM_W'($urandom_range(2, 24));
        end
        4: begin scr_w = 9'd256; scr_h = 9'd8; end
        5: begin scr_w = 9'd8; scr_h = 9'd300; end
        6: begin
          scr_w = DIM_W'($urandom_range(1, 32));
          scr_h = DIM_W'($urandom_range(1, 32));
        end
        default: begin scr_w = 9'd511; scr_h = 9'd511; end
      endcase
      // registers change only once the block has gone idle
      drain();
      cfg_valid <= 1'b1;
      cfg_index <= REG_SCREEN_W;
      cfg_data  <= scr_w;
      do @(posedge clk); while (!cfg_ready);
      mirror.write_reg(REG_SCREEN_W, scr_w);
      cfg_index <= REG_SCREEN_H;
      cfg_data  <= scr_h;
      do @(posedge clk); while (!cfg_ready);
      mirror.write_reg(REG_SCREEN_H, scr_h);
      cfg_valid <= 1'b0;

      phase_count = 0;
      if (p == 0) begin
        push_clear(8'h01, 8'h02, 8'h03);
        push_read(0, 0);
        push_read(0, 255);
        push_read(1, 0);
      end
      // oversized width saturates, the sprite closes after 256 texels
      if (p == 4) begin
        push_sprite(-2, 1, 300, 1, 260);
        push_read(0, 0);
        push_read(253, 0);
        push_read(254, 0);
        push_read(255, 0);
      end
      // oversized height saturates, top edge is bottom minus 256
      if (p == 5) begin
        push_sprite(3, 260, 1, 400, 258);
        push_read(3, 3);
        push_read(3, 4);
        push_read(3, 255);
      end

      while (phase_count < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          // well-formed sprite, then reads inside it
          sw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
          sh = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
          sx = near_coord(-sw, mirror.eff_w());
          sy = near_coord(0, mirror.eff_h() + sh);
          push_sprite(sx, sy, sw, sh, sw * sh);
          repeat ($urandom_range(1, 3)) begin
            push_read(sx + $urandom_range(0, sw - 1), sy - sh + $urandom_range(0, sh - 1));
          end
        end else if (pick < 60) begin
          // broken sprite: short, overlong or zero sized
          sw = $urandom_range(0, 6);
          sh = $urandom_range(0, 6);
          push_sprite(near_coord(-sw, mirror.eff_w()), near_coord(0, mirror.eff_h() + sh),
                      sw, sh, $urandom_range(0, sw * sh + 3));
        end else if (pick < 72) begin
          x = near_coord(-2, mirror.eff_w() + 1);
          y = near_coord(-2, mirror.eff_h() + 1);
          push_set(x, y, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
          push_read(x, y);
        end else if (pick < 88) begin
          push_read(near_coord(-2, mirror.eff_w() + 1), near_coord(-2, mirror.eff_h() + 1));
        end else if (pick < 93) begin
          if (mirror.eff_w() * mirror.eff_h() <= CLEAR_AREA_MAX) begin
            r = CHAN_W'($urandom);
            if ($urandom_range(0, 2) == 0) push_clear(r, r, r);
            else push_clear(r, CHAN_W'($urandom), CHAN_W'($urandom));
          end else begin
            push_read(near_coord(0, mirror.eff_w() - 1), near_coord(0, mirror.eff_h() - 1));
          end
        end else if (pick < 97) begin
          push_item(rand_item(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                              $urandom, $urandom), 1'b0);
        end else begin
          // noise: any non-clear command with random fields
          push_item(rand_item(CMD_W'($urandom_range(CMD_SET, CMD_READ)), $urandom, $urandom),
                    1'b1);
        end
      end
      run_stim();
    end

    drain();
    if (mirror.errors == 0 && mirror.pending_reads.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/csb_pkg.sv
design/csb_frame_ram.sv
design/csb_blend.sv
design/clipped_alpha_sprite_blitter_top.sv
sim/tb.sv
